// ===== rtl/core/wapa_pkg.sv =====
// Shared constants and types for the weighted average pollutant alert unit.
package wapa_pkg;

   // Geometry of the zone histories. ZONES is a power of two, so a zone
   // index is reduced to range by keeping its low bits.
   localparam int ZONES        = 8;
   localparam int WINDOW       = 30;
   localparam int CHANNELS     = 4;
   localparam int SAMPLE_W     = 20;
   localparam int ZONE_FIELD_W = 3;
   localparam int ZONE_W       = $clog2(ZONES);
   localparam int POS_W        = $clog2(WINDOW);

   // Sum widths: plain sum of the window and sum weighted WINDOW down to 1.
   localparam int WEIGHT_TOTAL = WINDOW * (WINDOW + 1) / 2;
   localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW);
   localparam int WSUM_W       = SAMPLE_W + $clog2(WEIGHT_TOTAL);

   // History memory holds one row of all channels per zone and slot.
   localparam int HIST_DEPTH = ZONES * WINDOW;
   localparam int HADDR_W    = $clog2(HIST_DEPTH);

   // Reciprocals for the constant divisions, scaled by two to the sum width.
   localparam logic [63:0] MEAN_RECIP = (64'd1 << SUM_W) / WINDOW;
   localparam logic [63:0] PRED_RECIP = (64'd1 << WSUM_W) / WEIGHT_TOTAL;

   // Result queue; depth is a power of two so the pointers wrap by themselves.
   localparam int QPTR_W      = 3;
   localparam int QUEUE_DEPTH = 1 << QPTR_W;
   localparam int QCNT_W      = QPTR_W + 1;

   // Channel order, shared by the samples, the limits and the mask bits.
   localparam int CH_CO2  = 0;
   localparam int CH_SO2  = 1;
   localparam int CH_NO2  = 2;
   localparam int CH_PM25 = 3;

   // Advice mask bits.
   localparam int ADVICE_W     = 3;
   localparam int ADV_OUTDOOR  = 0;
   localparam int ADV_VEHICLE  = 1;
   localparam int ADV_INDUSTRY = 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = $clog2(CHANNELS);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_CO2  = CSR_IDX_W'(CH_CO2);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_SO2  = CSR_IDX_W'(CH_SO2);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_NO2  = CSR_IDX_W'(CH_NO2);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PM25 = CSR_IDX_W'(CH_PM25);

   // Limits after reset, in hundredths; CO2 sits in the lowest bits.
   localparam logic [CHANNELS-1:0][SAMPLE_W-1:0] LIMIT_RESET =
      {20'd2500, 20'd4000, 20'd2000, 20'd50000};

   // Bus widths.
   localparam int REQ_DATA_W = ((CHANNELS * SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 * CHANNELS * SAMPLE_W + 2 * CHANNELS + ADVICE_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   // One row of samples, one per channel.
   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_row_type;

   // Running sums of one zone.
   typedef struct packed {
      logic [CHANNELS-1:0][SUM_W-1:0]  sum;
      logic [CHANNELS-1:0][WSUM_W-1:0] wsum;
   } zone_row_type;

endpackage

// ===== rtl/core/weighted_average_pollutant_alert_unit.sv =====
// Top level of the weighted average pollutant alert unit.
//
//  Channel  Direction  Payload
//  req_     in         tuser: zone; tdata: co2, so2, no2, pm25 samples
//  rsp_     out        tdata: four predictions, four means, alert, advice, exceed masks
//  csr_     in         index 0..3 selects a limit; data is the 20 bit limit
//
// One beat is accepted per cycle while req_tready is high, and results leave
// in request order through the result queue. The zone sum memory is read
// and written back once per beat, with the previous beat's sums forwarded
// when both hit the same zone. After reset a clearing pass zeroes all 240
// rows of the history memory, one row per cycle, and req_tready stays low
// meanwhile. Up to eight beats may be outstanding; when rsp_tready stalls,
// the result queue fills and req_tready drops until results are taken.
module weighted_average_pollutant_alert_unit
   import wapa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   // zone
   input  logic [ZONE_FIELD_W-1:0] req_tuser,
   // co2_sample, so2_sample, no2_sample, pm25_sample
   input  logic [REQ_DATA_W-1:0]   req_tdata,

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // pred_co2, pred_so2, pred_no2, pred_pm25, mean_co2, mean_so2, mean_no2,
   // mean_pm25, alert_mask, advice_mask, mean_exceed_mask, zero fill
   output logic [RSP_DATA_W-1:0]   rsp_tdata,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [SAMPLE_W-1:0]     csr_data
);

   // Storage.
   sample_row_type hist_mem [HIST_DEPTH];
   zone_row_type   zone_mem [ZONES];

   // Configuration and derived thresholds.
   logic [CHANNELS-1:0][SAMPLE_W-1:0] limit_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] limit_in;
   logic [CHANNELS-1:0][WSUM_W-1:0]   lim_wt_ff;
   logic [CHANNELS-1:0][SUM_W-1:0]    lim_win_ff;

   // Clearing pass.
   logic               clearing_ff;
   logic               clearing_in;
   logic [HADDR_W-1:0] clr_cnt_ff;
   logic [HADDR_W-1:0] clr_cnt_in;

   // Ring positions, one per zone.
   logic [POS_W-1:0] pos_ff [ZONES];

   // Intake.
   logic               accept;
   logic [ZONE_W-1:0]  zone_idx;
   logic [POS_W-1:0]   cur_pos;
   logic [HADDR_W-1:0] hist_addr;

   // Stage 1: memory data returns, sums are updated and written back.
   logic               p1_valid_ff;
   logic [ZONE_W-1:0]  p1_zone_ff;
   logic [HADDR_W-1:0] p1_addr_ff;
   sample_row_type     p1_x_ff;
   logic               p1_fwd_ff;
   sample_row_type     hist_rd_ff;
   zone_row_type       zone_rd_ff;
   zone_row_type       byp_ff;
   zone_row_type       old_row;
   zone_row_type       new_row;

   // Stage 2: reciprocal products and threshold compares.
   logic                              p2_valid_ff;
   zone_row_type                      p2_row_ff;
   sample_row_type                    p2_x_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] qw0;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] qs0;
   logic [CHANNELS-1:0]               alert;
   logic [CHANNELS-1:0]               exceed;
   logic [2*WSUM_W-1:0]               prod_w;
   logic [2*SUM_W-1:0]                prod_s;

   // Stage 3: quotient correction and result assembly.
   logic                              p3_valid_ff;
   zone_row_type                      p3_row_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] p3_qw_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] p3_qs_ff;
   logic [CHANNELS-1:0]               p3_alert_ff;
   logic [CHANNELS-1:0]               p3_exceed_ff;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] pred;
   logic [CHANNELS-1:0][SAMPLE_W-1:0] mean;
   logic [ADVICE_W-1:0]               advice;
   logic [WSUM_W-1:0]                 rem_w;
   logic [SUM_W-1:0]                  rem_s;
   logic [RSP_DATA_W-1:0]             rsp_word;

   // Result queue and outstanding count.
   logic [RSP_DATA_W-1:0] queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_in;
   logic [QCNT_W-1:0]     q_cnt_ff;
   logic [QCNT_W-1:0]     q_cnt_in;
   logic [QCNT_W-1:0]     out_cnt_ff;
   logic [QCNT_W-1:0]     out_cnt_in;
   logic                  pop;

   // Handshakes.
   assign csr_ready  = 1'b1;
   assign req_tready = !clearing_ff && (out_cnt_ff < QCNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;

   // Zone index and history row address of the incoming beat.
   assign zone_idx  = req_tuser[ZONE_W-1:0];
   assign cur_pos   = pos_ff[zone_idx];
   assign hist_addr = HADDR_W'(HADDR_W'(zone_idx) * HADDR_W'(WINDOW)) + HADDR_W'(cur_pos);

   // Limit register writes.
   always_comb begin
      limit_in = limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LIMIT_CO2:  limit_in[CH_CO2]  = csr_data;
            CSR_LIMIT_SO2:  limit_in[CH_SO2]  = csr_data;
            CSR_LIMIT_NO2:  limit_in[CH_NO2]  = csr_data;
            CSR_LIMIT_PM25: limit_in[CH_PM25] = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Scaled limits, so the averages are compared before truncation.
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         lim_wt_ff[c]  <= WSUM_W'(limit_ff[c]) * WSUM_W'(WEIGHT_TOTAL);
         lim_win_ff[c] <= SUM_W'(limit_ff[c]) * SUM_W'(WINDOW);
      end
   end

   // Clearing pass sweeps the history rows after reset.
   always_comb begin
      clearing_in = clearing_ff && (clr_cnt_ff != HADDR_W'(HIST_DEPTH - 1));
      clr_cnt_in  = clearing_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // Ring positions advance when a beat of their zone is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            pos_ff[z] <= '0;
         end
      end else if (accept) begin
         pos_ff[zone_idx] <= (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
      end
   end

   // History memory: the oldest row of the zone is read as the new one is taken.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         hist_mem[clr_cnt_ff] <= '0;
      end else if (p1_valid_ff) begin
         hist_mem[p1_addr_ff] <= p1_x_ff;
      end
      hist_rd_ff <= hist_mem[hist_addr];
   end

   // Zone sum memory: read at intake, written back from stage 1.
   always_ff @(posedge clock) begin
      if (clearing_ff && (clr_cnt_ff < HADDR_W'(ZONES))) begin
         zone_mem[clr_cnt_ff[ZONE_W-1:0]] <= '0;
      end else if (p1_valid_ff) begin
         zone_mem[p1_zone_ff] <= new_row;
      end
      zone_rd_ff <= zone_mem[zone_idx];
   end

   // Stage 1 registers. The forward flag marks a beat that follows one of the
   // same zone, whose write-back lands on the same edge as this read.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= accept;
      end
      p1_zone_ff <= zone_idx;
      p1_addr_ff <= hist_addr;
      p1_x_ff    <= sample_row_type'(req_tdata[CHANNELS*SAMPLE_W-1:0]);
      p1_fwd_ff  <= p1_valid_ff && (p1_zone_ff == zone_idx);
      byp_ff     <= new_row;
   end

   // Running sum update: the weighted sum gains WINDOW times the new sample
   // and loses one copy of every entry, which is the old plain sum.
   always_comb begin
      old_row = p1_fwd_ff ? byp_ff : zone_rd_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         new_row.sum[c]  = old_row.sum[c] + SUM_W'(p1_x_ff[c]) - SUM_W'(hist_rd_ff[c]);
         new_row.wsum[c] = old_row.wsum[c] + WSUM_W'(p1_x_ff[c]) * WSUM_W'(WINDOW)
                           - WSUM_W'(old_row.sum[c]);
      end
   end

   // Stage 2 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_row_ff <= new_row;
      p2_x_ff   <= p1_x_ff;
   end

   // Quotient estimates by reciprocal, at most one below the true value.
   always_comb begin
      prod_w = '0;
      prod_s = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         prod_w    = (2*WSUM_W)'(p2_row_ff.wsum[c]) * (2*WSUM_W)'(PRED_RECIP[WSUM_W-1:0]);
         prod_s    = (2*SUM_W)'(p2_row_ff.sum[c]) * (2*SUM_W)'(MEAN_RECIP[SUM_W-1:0]);
         qw0[c]    = prod_w[WSUM_W +: SAMPLE_W];
         qs0[c]    = prod_s[SUM_W +: SAMPLE_W];
         alert[c]  = (p2_x_ff[c] > limit_ff[c]) || (p2_row_ff.wsum[c] > lim_wt_ff[c]);
         exceed[c] = p2_row_ff.sum[c] > lim_win_ff[c];
      end
   end

   // Stage 3 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_row_ff    <= p2_row_ff;
      p3_qw_ff     <= qw0;
      p3_qs_ff     <= qs0;
      p3_alert_ff  <= alert;
      p3_exceed_ff <= exceed;
   end

   // Correct each estimate by one where the remainder reaches the divisor.
   always_comb begin
      rem_w = '0;
      rem_s = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         rem_w   = p3_row_ff.wsum[c] - WSUM_W'(p3_qw_ff[c]) * WSUM_W'(WEIGHT_TOTAL);
         rem_s   = p3_row_ff.sum[c] - SUM_W'(p3_qs_ff[c]) * SUM_W'(WINDOW);
         pred[c] = (rem_w >= WSUM_W'(WEIGHT_TOTAL)) ? p3_qw_ff[c] + 1'b1 : p3_qw_ff[c];
         mean[c] = (rem_s >= SUM_W'(WINDOW)) ? p3_qs_ff[c] + 1'b1 : p3_qs_ff[c];
      end
      advice               = '0;
      advice[ADV_OUTDOOR]  = p3_alert_ff[CH_PM25] || p3_alert_ff[CH_NO2];
      advice[ADV_VEHICLE]  = p3_alert_ff[CH_CO2];
      advice[ADV_INDUSTRY] = p3_alert_ff[CH_SO2];
      rsp_word = {{RSP_PAD_W{1'b0}}, p3_exceed_ff, advice, p3_alert_ff, mean, pred};
   end

   // Result queue bookkeeping.
   always_comb begin
      wr_ptr_in  = p3_valid_ff ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      q_cnt_in   = q_cnt_ff + QCNT_W'(p3_valid_ff) - QCNT_W'(pop);
      out_cnt_in = out_cnt_ff + QCNT_W'(accept) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_cnt_ff   <= '0;
         out_cnt_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_cnt_ff   <= q_cnt_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   // Queue storage; the outstanding limit keeps it from overflowing.
   always_ff @(posedge clock) begin
      if (p3_valid_ff) begin
         queue_ff[wr_ptr_ff] <= rsp_word;
      end
   end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the weighted average pollutant alert unit.
`timescale 1ns / 1ps

module tb_top;
   import wapa_pkg::*;

   // Content of one response beat; member order matches the rsp_tdata packing.
   typedef struct packed {
      logic [CHANNELS-1:0]               exceed;
      logic [ADVICE_W-1:0]               advice;
      logic [CHANNELS-1:0]               alert;
      logic [CHANNELS-1:0][SAMPLE_W-1:0] mean;
      logic [CHANNELS-1:0][SAMPLE_W-1:0] pred;
   } air_report_type;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [CHANNELS-1:0][CSR_IDX_W-1:0] LIMIT_REG =
      {CSR_LIMIT_PM25, CSR_LIMIT_NO2, CSR_LIMIT_SO2, CSR_LIMIT_CO2};

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ZONE_FIELD_W-1:0] req_tuser  = '0;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [SAMPLE_W-1:0]     csr_data   = '0;

   // Local copy of the limits and the per-zone histories and running sums.
   logic [SAMPLE_W-1:0] alarm_limit  [CHANNELS];
   logic [SAMPLE_W-1:0] zone_history [ZONES][WINDOW][CHANNELS];
   logic [63:0]         zone_sum     [ZONES][CHANNELS];
   logic [63:0]         zone_wsum    [ZONES][CHANNELS];
   int                  ring_slot    [ZONES];

   air_report_type          reports_due [$];
   int                      error_count = 0;
   bit                      steady_flow = 1'b0;
   logic [ZONE_FIELD_W-1:0] last_zone   = '0;

   weighted_average_pollutant_alert_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Push one sample row into its zone and work out the response it causes.
   function automatic air_report_type predict_air_report(
      input logic [ZONE_FIELD_W-1:0] zone_id,
      input sample_row_type          smp);
      air_report_type rep;
      int             z;
      int             slot;
      int             c;
      logic [63:0]    x, lim, w, s;
      rep  = '0;
      z    = int'(zone_id) % ZONES;
      slot = ring_slot[z] % WINDOW;
      for (c = 0; c < CHANNELS; c++) begin
         x   = 64'(smp[c]);
         lim = 64'(alarm_limit[c]);
         // Every older entry drops one weight step when a new one enters.
         w = zone_wsum[z][c] + 64'(WINDOW) * x - zone_sum[z][c];
         s = zone_sum[z][c] + x - 64'(zone_history[z][slot][c]);
         zone_wsum[z][c] = w;
         zone_sum[z][c]  = s;
         zone_history[z][slot][c] = smp[c];
         rep.pred[c] = SAMPLE_W'(w / 64'(WEIGHT_TOTAL));
         rep.mean[c] = SAMPLE_W'(s / 64'(WINDOW));
         // Thresholds apply to the exact averages, so a fractional excess counts.
         rep.alert[c]  = (x > lim) || (w > lim * 64'(WEIGHT_TOTAL));
         rep.exceed[c] = s > lim * 64'(WINDOW);
      end
      ring_slot[z] = (slot + 1) % WINDOW;
      rep.advice[ADV_OUTDOOR]  = rep.alert[CH_NO2] | rep.alert[CH_PM25];
      rep.advice[ADV_VEHICLE]  = rep.alert[CH_CO2];
      rep.advice[ADV_INDUSTRY] = rep.alert[CH_SO2];
      return rep;
   endfunction

   // Samples mostly straddle each channel's limit, with zeros, maxima and noise mixed in.
   function automatic sample_row_type draw_samples();
      sample_row_type smp;
      int             c;
      int unsigned    span;
      for (c = 0; c < CHANNELS; c++) begin
         span = 2 * 32'(alarm_limit[c]) + 2;
         if (span > 32'(SAMPLE_MAX)) span = 32'(SAMPLE_MAX);
         case ($urandom_range(0, 9))
            0: begin
               smp[c] = '0;
            end
            1: begin
               smp[c] = SAMPLE_MAX;
            end
            2, 3: begin
               smp[c] = SAMPLE_W'($urandom);
            end
            default: begin
               smp[c] = SAMPLE_W'($urandom_range(0, span));
            end
         endcase
      end
      return smp;
   endfunction

   function automatic void compare_field(input string label, input int ch,
                                         input logic [31:0] want, input logic [31:0] seen);
      if (want !== seen) begin
         error_count++;
         $display("%0t: %s[%0d] expected %0d, got %0d", $time, label, ch, want, seen);
      end
   endfunction

   // Send one request beat; valid stays high afterwards unless the next beat idles first.
   task automatic send_reading(input logic [ZONE_FIELD_W-1:0] zone_id, input sample_row_type smp);
      if (!steady_flow && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= zone_id;
      req_tdata  <= REQ_DATA_W'(smp);
      do @(posedge clock); while (!req_tready);
      reports_due.push_back(predict_air_report(zone_id, smp));
      last_zone = zone_id;
   endtask

   // Limits are written only once the unit has drained every response.
   task automatic program_limits(input logic [CHANNELS-1:0][SAMPLE_W-1:0] lims);
      int c;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      for (c = 0; c < CHANNELS; c++) begin
         csr_valid <= 1'b1;
         csr_index <= LIMIT_REG[c];
         csr_data  <= lims[c];
         do @(posedge clock); while (!csr_ready);
         alarm_limit[LIMIT_REG[c]] = lims[c];
      end
      csr_valid <= 1'b0;
   endtask

   // Random beats; zones often repeat back to back to hit the sum forwarding path.
   task automatic run_random_readings(input int count, input int calm_from, input int calm_to);
      logic [ZONE_FIELD_W-1:0] zone_id;
      int                      n;
      for (n = 0; n < count; n++) begin
         steady_flow = (n >= calm_from) && (n < calm_to);
         zone_id = ($urandom_range(0, 99) < 40) ? last_zone : ZONE_FIELD_W'($urandom);
         send_reading(zone_id, draw_samples());
      end
      req_tvalid <= 1'b0;
      steady_flow = 1'b0;
   endtask

   // Every zone index, all-zero and all-one samples, and alternating bit patterns.
   task automatic test_field_extremes();
      int z;
      for (z = 0; z < ZONES; z++) send_reading(ZONE_FIELD_W'(z), '0);
      send_reading(3'd7, {CHANNELS{SAMPLE_MAX}});
      send_reading(3'd7, '0);
      send_reading(3'd5, {CHANNELS{20'hAAAAA}});
      send_reading(3'd5, {CHANNELS{20'h55555}});
      req_tvalid <= 1'b0;
   endtask

   // With a limit of one, a beat of 31 followed by a zero truncates both averages
   // to exactly one while the exact values sit above it.
   task automatic test_fractional_excess();
      program_limits({CHANNELS{20'd1}});
      send_reading(3'd3, {CHANNELS{20'd31}});
      send_reading(3'd3, '0);
      // Exactly at the limit nothing is flagged.
      send_reading(3'd4, {CHANNELS{20'd1}});
      // Partial alerts give partial advice.
      send_reading(3'd6, {20'd0, 20'd2, 20'd0, 20'd2});
      send_reading(3'd6, {20'd2, 20'd0, 20'd2, 20'd0});
      req_tvalid <= 1'b0;
   endtask

   task automatic test_random_limits();
      logic [CHANNELS-1:0][SAMPLE_W-1:0] lims;
      int                                c;
      for (c = 0; c < CHANNELS; c++)
         lims[c] = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom)
                                               : SAMPLE_W'($urandom_range(0, 4095));
      program_limits(lims);
      run_random_readings(200, 60, 160);
   endtask

   task automatic test_zero_limits();
      program_limits('0);
      run_random_readings(100, 0, 0);
   endtask

   task automatic test_max_limits();
      program_limits({CHANNELS{SAMPLE_MAX}});
      run_random_readings(100, 0, 0);
   endtask

   task automatic test_mixed_limits();
      program_limits({20'd0, SAMPLE_MAX, SAMPLE_W'($urandom_range(0, 4095)),
                      SAMPLE_W'($urandom)});
      run_random_readings(150, 0, 0);
   endtask

   task automatic test_default_limits();
      program_limits(LIMIT_RESET);
      run_random_readings(200, 0, 0);
   endtask

   // Response side: random back-pressure and in-order comparison.
   always @(posedge clock) begin
      air_report_type seen;
      air_report_type want;
      int             c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = air_report_type'(rsp_tdata[RSP_BITS-1:0]);
         if (reports_due.size() == 0) begin
            error_count++;
            $display("%0t: response beat with nothing expected, got %h", $time, rsp_tdata);
         end else begin
            want = reports_due.pop_front();
            for (c = 0; c < CHANNELS; c++) begin
               compare_field("pred", c, 32'(want.pred[c]), 32'(seen.pred[c]));
               compare_field("mean", c, 32'(want.mean[c]), 32'(seen.mean[c]));
            end
            compare_field("alert_mask", 0, 32'(want.alert), 32'(seen.alert));
            compare_field("advice_mask", 0, 32'(want.advice), 32'(seen.advice));
            compare_field("mean_exceed_mask", 0, 32'(want.exceed), 32'(seen.exceed));
         end
      end
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 15);
   end

   initial begin : main
      int z;
      int k;
      int c;
      for (z = 0; z < ZONES; z++) begin
         ring_slot[z] = 0;
         for (c = 0; c < CHANNELS; c++) begin
            zone_sum[z][c]  = '0;
            zone_wsum[z][c] = '0;
            for (k = 0; k < WINDOW; k++) zone_history[z][k][c] = '0;
         end
      end
      for (c = 0; c < CHANNELS; c++) alarm_limit[c] = LIMIT_RESET[c];

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_fractional_excess();
      test_random_limits();
      test_zero_limits();
      test_max_limits();
      test_mixed_limits();
      test_default_limits();

      // Drain outstanding responses, then allow for the pipeline depth.
      for (k = 0; k < 5000 && reports_due.size() != 0; k++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (reports_due.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, reports_due.size());
      end
      if (error_count == 0) begin
         $display("weighted_average_pollutant_alert_unit: match");
      end else begin
         $display("weighted_average_pollutant_alert_unit: mismatch");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("weighted_average_pollutant_alert_unit: mismatch");
      $finish;
   end

endmodule
